### hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by hdl/websocket_frame_deframer.sv.
`default_nettype none

package wsd_pkg;

    // Header parser phases
    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_LEN  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_TEXT_SINGLE = 3'd0;
    localparam logic [2:0] KIND_TEXT_FRAG   = 3'd1;
    localparam logic [2:0] KIND_PING        = 3'd2;
    localparam logic [2:0] KIND_CLOSE       = 3'd3;
    localparam logic [2:0] KIND_DISCARD     = 3'd4;
    localparam logic [2:0] KIND_LEN_ERR     = 3'd5;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // Second header byte length codes
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam int          MAX_LEN_W     = 63;
    localparam logic [62:0] MAX_LEN_RESET = 63'd2147483647;

    // One result transfer
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

### hdl/websocket_frame_deframer.sv
// WebSocket frame deframer: header parse, unmasking and fragment tracking.
// Depends on hdl/wsd_pkg.sv.
// Results are registered (out_data_reg, or skid_data_reg while the output holds).
// Throughput: one byte per cycle while skid is empty; a single state pass per byte.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (rst_n low, asynchronous): parser idle, no fragment open, not halted,
// max_frame_length back to 2147483647, output buffer empty.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [62:0] cfg_wdata,     // max_frame_length
    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic        s_axis_tuser,  // [0] restart
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] payload_byte
    output logic [3:0]       m_axis_tuser,  // [2:0] kind, [3] has_byte
    output logic             m_axis_tlast   // last
);

    import wsd_pkg::*;

    // Parser state
    phase_t         phase_reg, phase_next;
    logic           final_reg, final_next;
    logic [3:0]     opcode_reg, opcode_next;
    logic           masked_reg, masked_next;
    logic [3:0]     len_left_reg, len_left_next;
    logic [63:0]    pay_left_reg, pay_left_next;
    logic [31:0]    mask_key_reg, mask_key_next;
    logic [1:0]     mask_pos_reg, mask_pos_next;
    logic [3:0]     open_op_reg, open_op_next;
    logic           halted_reg, halted_next;
    logic [62:0]    max_len_reg;

    // Output buffer
    logic           out_valid_reg, skid_valid_reg;
    result_t        out_data_reg, skid_data_reg;

    logic           in_xfer, out_pop;
    logic           res_valid;
    result_t        res;
    logic           after_len, hdr_done;
    logic [7:0]     key_byte, unmasked;
    logic           data_end, frag_start;

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_pop       = out_valid_reg && m_axis_tready;

    // Mask key byte for the current payload position, most significant first
    always_comb
    begin
        case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    assign unmasked = masked_reg ? (s_axis_tdata ^ key_byte) : s_axis_tdata;
    assign data_end = (pay_left_reg == 64'd1);

    // Next parser state and result for the byte in transfer
    always_comb
    begin
        phase_next    = phase_reg;
        final_next    = final_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        len_left_next = len_left_reg;
        pay_left_next = pay_left_reg;
        mask_key_next = mask_key_reg;
        mask_pos_next = mask_pos_reg;
        open_op_next  = open_op_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        res           = '0;
        after_len     = 1'b0;
        hdr_done      = 1'b0;
        frag_start    = 1'b0;

        if (in_xfer)
        begin
            if (s_axis_tuser)
            begin
                phase_next    = PH_HDR1;
                final_next    = 1'b0;
                opcode_next   = OP_CONT;
                masked_next   = 1'b0;
                len_left_next = 4'd0;
                pay_left_next = 64'd0;
                mask_key_next = 32'd0;
                mask_pos_next = 2'd0;
                open_op_next  = OP_CONT;
                halted_next   = 1'b0;
            end
            else if (!halted_reg)
            begin
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        final_next  = s_axis_tdata[7];
                        opcode_next = s_axis_tdata[3:0];
                        phase_next  = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        masked_next   = s_axis_tdata[7];
                        mask_key_next = 32'd0;
                        pay_left_next = 64'd0;
                        if (s_axis_tdata[6:0] == LEN_CODE_16)
                        begin
                            len_left_next = 4'd2;
                            phase_next    = PH_LEN;
                        end
                        else if (s_axis_tdata[6:0] == LEN_CODE_64)
                        begin
                            len_left_next = 4'd8;
                            phase_next    = PH_LEN;
                        end
                        else
                        begin
                            pay_left_next = {57'd0, s_axis_tdata[6:0]};
                            after_len     = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        pay_left_next = {pay_left_reg[55:0], s_axis_tdata};
                        len_left_next = len_left_reg - 4'd1;
                        after_len     = (len_left_next == 4'd0);
                    end
                    PH_MASK:
                    begin
                        mask_key_next = {mask_key_reg[23:0], s_axis_tdata};
                        mask_pos_next = mask_pos_reg + 2'd1;
                        hdr_done      = (mask_pos_next == 2'd0);
                    end
                    PH_DATA:
                    begin
                        if (masked_reg)
                            mask_pos_next = mask_pos_reg + 2'd1;
                        pay_left_next = pay_left_reg - 64'd1;
                        case (opcode_reg)
                            OP_CONT:
                            begin
                                if (open_op_reg == OP_TEXT)
                                begin
                                    res_valid = 1'b1;
                                    res = '{KIND_TEXT_FRAG, unmasked, 1'b1,
                                            final_reg && data_end};
                                end
                            end
                            OP_TEXT:
                            begin
                                res_valid = 1'b1;
                                if (final_reg)
                                    res = '{KIND_TEXT_SINGLE, unmasked, 1'b1, data_end};
                                else
                                    res = '{KIND_TEXT_FRAG, unmasked, 1'b1, 1'b0};
                            end
                            OP_CLOSE:
                            begin
                                if (data_end)
                                begin
                                    halted_next = 1'b1;
                                    res_valid   = 1'b1;
                                    res = '{KIND_CLOSE, 8'd0, 1'b0, 1'b0};
                                end
                            end
                            OP_PING:
                            begin
                                res_valid = 1'b1;
                                res = '{KIND_PING, unmasked, 1'b1, data_end};
                            end
                            default:
                            begin
                            end
                        endcase
                        if (data_end)
                        begin
                            if (opcode_reg == OP_CONT && final_reg)
                                open_op_next = OP_CONT;
                            phase_next    = PH_HDR1;
                            mask_pos_next = 2'd0;
                        end
                    end
                    default:
                        phase_next = PH_HDR1;
                endcase
            end
        end

        // Length complete: go to mask key or finish header
        if (after_len)
        begin
            if (masked_next)
            begin
                phase_next    = PH_MASK;
                mask_pos_next = 2'd0;
            end
            else
                hdr_done = 1'b1;
        end

        // Header complete: length check, fragment tracking, empty frames
        if (hdr_done)
        begin
            mask_pos_next = 2'd0;
            frag_start = !final_reg && (opcode_reg == OP_TEXT || opcode_reg == OP_BINARY);
            if (pay_left_next > {1'b0, max_len_reg})
            begin
                halted_next = 1'b1;
                phase_next  = PH_HDR1;
                res_valid   = 1'b1;
                res = '{KIND_LEN_ERR, 8'd0, 1'b0, 1'b0};
            end
            else if (frag_start)
            begin
                if (open_op_reg == OP_TEXT)
                begin
                    res_valid = 1'b1;
                    res = '{KIND_DISCARD, 8'd0, 1'b0, 1'b0};
                end
                open_op_next = opcode_reg;
                phase_next   = (pay_left_next == 64'd0) ? PH_HDR1 : PH_DATA;
            end
            else if (pay_left_next == 64'd0)
            begin
                // zero-length frame ends here
                phase_next = PH_HDR1;
                case (opcode_reg)
                    OP_CONT:
                    begin
                        if (final_reg)
                        begin
                            if (open_op_reg == OP_TEXT)
                            begin
                                res_valid = 1'b1;
                                res = '{KIND_TEXT_FRAG, 8'd0, 1'b0, 1'b1};
                            end
                            open_op_next = OP_CONT;
                        end
                    end
                    OP_TEXT:
                    begin
                        if (final_reg)
                        begin
                            res_valid = 1'b1;
                            res = '{KIND_TEXT_SINGLE, 8'd0, 1'b0, 1'b1};
                        end
                    end
                    OP_CLOSE:
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res = '{KIND_CLOSE, 8'd0, 1'b0, 1'b0};
                    end
                    OP_PING:
                    begin
                        res_valid = 1'b1;
                        res = '{KIND_PING, 8'd0, 1'b0, 1'b1};
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
                phase_next = PH_DATA;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR1;
            final_reg    <= 1'b0;
            opcode_reg   <= OP_CONT;
            masked_reg   <= 1'b0;
            len_left_reg <= 4'd0;
            pay_left_reg <= 64'd0;
            mask_key_reg <= 32'd0;
            mask_pos_reg <= 2'd0;
            open_op_reg  <= OP_CONT;
            halted_reg   <= 1'b0;
            max_len_reg  <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            final_reg    <= final_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            len_left_reg <= len_left_next;
            pay_left_reg <= pay_left_next;
            mask_key_reg <= mask_key_next;
            mask_pos_reg <= mask_pos_next;
            open_op_reg  <= open_op_next;
            halted_reg   <= halted_next;
            if (cfg_we)
                max_len_reg <= cfg_wdata;
        end
    end

    // Output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_pop)
            out_valid_reg <= 1'b0;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_pop)
                skid_data_reg <= res;
            else
                out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.data;
    assign m_axis_tuser  = {out_data_reg.has_byte, out_data_reg.kind};
    assign m_axis_tlast  = out_data_reg.last;

endmodule

`default_nettype wire

### tb/websocket_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench for websocket_frame_deframer. A short table of directed frames runs first, then
// random frame streams under several length limits, with random stalls on both buses.
// Depends on hdl/wsd_pkg.sv and hdl/websocket_frame_deframer.sv; results checked in order.

module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam logic [3:0] OP_PONG       = 4'hA;
    localparam logic [3:0] FRAG_NONE     = 4'h0;
    localparam result_t    NO_RES        = '0;
    localparam int         STALL_MAX     = 12;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         ITEM_TARGET   = 1050;
    localparam int         N_DIRECTED    = 28;
    localparam int         N_LIMITS      = 7;
    localparam int         MAX_REPORTS   = 10;

    typedef struct {
        logic [7:0] rx;
        logic       rst_req;
        bit         pinned;
        result_t    want;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [62:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] rx_byte
    logic        s_axis_tuser  = 1'b0;  // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] payload_byte
    logic [3:0]  m_axis_tuser;          // [2:0] kind, [3] has_byte
    logic        m_axis_tlast;          // last

    // Parser copy used for prediction
    phase_t      prs_phase;
    logic        prs_fin;
    logic [3:0]  prs_op;
    logic        prs_masked;
    logic [3:0]  prs_len_todo;
    logic [63:0] prs_remaining;
    logic [31:0] prs_key;
    logic [1:0]  prs_key_idx;
    logic [3:0]  prs_frag_op;
    logic        prs_halted;
    logic [62:0] prs_max_len;

    result_t     pending_results [$];
    int          fail_count    = 0;
    int          bytes_sent    = 0;
    bit          tx_calm       = 1'b0;
    bit          tx_burst      = 1'b0;
    bit          hold_pending  = 1'b0;
    logic [62:0] len_limits [N_LIMITS];

    // Directed frames; rows with an obvious outcome carry it typed in
    stim_row_t directed [N_DIRECTED] = '{
        // single-frame text, one byte
        '{8'h81, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, '{KIND_TEXT_SINGLE, 8'hFF, 1'b1, 1'b1}},
        // empty text message
        '{8'h81, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{KIND_TEXT_SINGLE, 8'h00, 1'b0, 1'b1}},
        // empty ping
        '{8'h89, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{KIND_PING, 8'h00, 1'b0, 1'b1}},
        // open a fragment, then open another, discarding the first
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{KIND_DISCARD, 8'h00, 1'b0, 1'b0}},
        // empty final continuation ends the message
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{KIND_TEXT_FRAG, 8'h00, 1'b0, 1'b1}},
        // 64-bit length of all ones is over any limit
        '{8'h82, 1'b0, 1'b0, NO_RES},
        '{8'h7F, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, '{KIND_LEN_ERR, 8'h00, 1'b0, 1'b0}},
        // halted: byte dropped, then restart
        '{8'hAA, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, NO_RES},
        // empty close halts again
        '{8'h88, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, '{KIND_CLOSE, 8'h00, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 1'b0, NO_RES}
    };

    websocket_frame_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void parser_clear();
        prs_phase     = PH_HDR1;
        prs_fin       = 1'b0;
        prs_op        = 4'h0;
        prs_masked    = 1'b0;
        prs_len_todo  = 4'd0;
        prs_remaining = 64'd0;
        prs_key       = 32'd0;
        prs_key_idx   = 2'd0;
        prs_frag_op   = FRAG_NONE;
        prs_halted    = 1'b0;
    endfunction

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] b,
                                            input logic has, input logic last);
        result_t r;
        r.kind     = kind;
        r.data     = has ? b : 8'h00;
        r.has_byte = has;
        r.last     = last;
        return r;
    endfunction

    // Header complete: length check, fragment bookkeeping, zero-length frames
    function automatic bit header_complete(output result_t res);
        bit got;
        got = 1'b0;
        res = NO_RES;
        prs_key_idx = 2'd0;
        if (prs_remaining > {1'b0, prs_max_len})
        begin
            prs_halted = 1'b1;
            prs_phase  = PH_HDR1;
            res = make_result(KIND_LEN_ERR, 8'h00, 1'b0, 1'b0);
            return 1'b1;
        end
        // non-final text or binary opens a new fragment, dropping an open text one
        if (!prs_fin && (prs_op == OP_TEXT || prs_op == OP_BINARY))
        begin
            if (prs_frag_op == OP_TEXT)
            begin
                got = 1'b1;
                res = make_result(KIND_DISCARD, 8'h00, 1'b0, 1'b0);
            end
            prs_frag_op = prs_op;
            if (prs_remaining == 64'd0)
            begin
                prs_phase = PH_HDR1;
                return got;
            end
        end
        if (prs_remaining != 64'd0)
        begin
            prs_phase = PH_DATA;
            return got;
        end
        // zero-length frame ends here
        prs_phase = PH_HDR1;
        case (prs_op)
            OP_CONT:
            begin
                if (prs_fin)
                begin
                    if (prs_frag_op == OP_TEXT)
                    begin
                        got = 1'b1;
                        res = make_result(KIND_TEXT_FRAG, 8'h00, 1'b0, 1'b1);
                    end
                    prs_frag_op = FRAG_NONE;
                end
            end
            OP_TEXT:
            begin
                if (prs_fin)
                begin
                    got = 1'b1;
                    res = make_result(KIND_TEXT_SINGLE, 8'h00, 1'b0, 1'b1);
                end
            end
            OP_CLOSE:
            begin
                prs_halted = 1'b1;
                got = 1'b1;
                res = make_result(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
            end
            OP_PING:
            begin
                got = 1'b1;
                res = make_result(KIND_PING, 8'h00, 1'b0, 1'b1);
            end
            default: ;
        endcase
        return got;
    endfunction

    function automatic bit length_complete(output result_t res);
        res = NO_RES;
        if (prs_masked)
        begin
            prs_phase   = PH_MASK;
            prs_key_idx = 2'd0;
            return 1'b0;
        end
        return header_complete(res);
    endfunction

    // Next parser state for one accepted byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, input logic rst_req,
                                        output result_t res);
        logic [7:0] plain;
        logic       at_end;
        bit         got;
        got = 1'b0;
        res = NO_RES;
        if (rst_req)
        begin
            parser_clear();
            return 1'b0;
        end
        if (prs_halted)
            return 1'b0;
        case (prs_phase)
            PH_HDR1:
            begin
                prs_fin   = b[7];
                prs_op    = b[3:0];
                prs_phase = PH_HDR2;
            end
            PH_HDR2:
            begin
                prs_masked    = b[7];
                prs_key       = 32'd0;
                prs_remaining = 64'd0;
                if (b[6:0] == LEN_CODE_16)
                begin
                    prs_len_todo = 4'd2;
                    prs_phase    = PH_LEN;
                end
                else if (b[6:0] == LEN_CODE_64)
                begin
                    prs_len_todo = 4'd8;
                    prs_phase    = PH_LEN;
                end
                else
                begin
                    prs_remaining = {57'd0, b[6:0]};
                    got = length_complete(res);
                end
            end
            PH_LEN:
            begin
                prs_remaining = {prs_remaining[55:0], b};
                prs_len_todo  = prs_len_todo - 4'd1;
                if (prs_len_todo == 4'd0)
                    got = length_complete(res);
            end
            PH_MASK:
            begin
                prs_key     = {prs_key[23:0], b};
                prs_key_idx = prs_key_idx + 2'd1;
                if (prs_key_idx == 2'd0)
                    got = header_complete(res);
            end
            PH_DATA:
            begin
                plain = b;
                if (prs_masked)
                begin
                    plain = plain ^ prs_key[5'd24 - {prs_key_idx, 3'b000} +: 8];
                    prs_key_idx = prs_key_idx + 2'd1;
                end
                prs_remaining = prs_remaining - 64'd1;
                at_end = (prs_remaining == 64'd0);
                case (prs_op)
                    OP_CONT:
                    begin
                        if (prs_frag_op == OP_TEXT)
                        begin
                            got = 1'b1;
                            res = make_result(KIND_TEXT_FRAG, plain, 1'b1, prs_fin && at_end);
                        end
                    end
                    OP_TEXT:
                    begin
                        got = 1'b1;
                        if (prs_fin)
                            res = make_result(KIND_TEXT_SINGLE, plain, 1'b1, at_end);
                        else
                            res = make_result(KIND_TEXT_FRAG, plain, 1'b1, 1'b0);
                    end
                    OP_CLOSE:
                    begin
                        if (at_end)
                        begin
                            prs_halted = 1'b1;
                            got = 1'b1;
                            res = make_result(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
                        end
                    end
                    OP_PING:
                    begin
                        got = 1'b1;
                        res = make_result(KIND_PING, plain, 1'b1, at_end);
                    end
                    default: ;
                endcase
                if (at_end)
                begin
                    if (prs_op == OP_CONT && prs_fin)
                        prs_frag_op = FRAG_NONE;
                    prs_phase   = PH_HDR1;
                    prs_key_idx = 2'd0;
                end
            end
            default: prs_phase = PH_HDR1;
        endcase
        return got;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // One byte transfer on the slave side; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic rst_req, input bit pinned,
                             input result_t pinned_res);
        int      gap;
        bit      got;
        result_t res;
        gap = (tx_calm || tx_burst) ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rst_req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = deframe_byte(b, rst_req, res);
        if (pinned)
            pending_results.push_back(pinned_res);
        else if (got)
            pending_results.push_back(res);
        bytes_sent++;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_byte(b, 1'b0, 1'b0, NO_RES);
    endtask

    // Limit write with the block idle: all results in, then a short settle
    task automatic write_max_len(input logic [62:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        prs_max_len = value;
    endtask

    // One random frame; now and then cut short or followed by noise, then a restart
    task automatic send_frame();
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        logic [63:0] len;
        logic [6:0]  len_code;
        logic [31:0] key;
        int          pick;
        int          n_len_bytes;
        int          cut;
        int          i;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_TEXT;
        else if (pick < 55)
            op = OP_CONT;
        else if (pick < 68)
            op = OP_PING;
        else if (pick < 76)
            op = OP_BINARY;
        else if (pick < 79)
            op = OP_CLOSE;
        else if (pick < 85)
            op = OP_PONG;
        else
            op = 4'($urandom_range(0, 15));
        fin    = ($urandom_range(0, 2) != 0);
        masked = 1'($urandom_range(0, 1));
        n_len_bytes = 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            len = 64'($urandom_range(0, 20));
        else if (pick < 78)
            len = 64'($urandom_range(0, 125));
        else if (pick < 88)
        begin
            len = 64'($urandom_range(0, 300));
            n_len_bytes = 2;
        end
        else if (pick < 96)
        begin
            len = 64'($urandom_range(0, 300));
            n_len_bytes = 8;
        end
        else
        begin
            // top bit set: above every limit
            len = {1'b1, 31'($urandom), 32'($urandom)};
            n_len_bytes = 8;
        end
        if (n_len_bytes == 2)
            len_code = LEN_CODE_16;
        else if (n_len_bytes == 8)
            len_code = LEN_CODE_64;
        else
            len_code = len[6:0];

        // header, extended length big-endian, mask key
        push_byte({fin, 3'($urandom), op});
        push_byte({masked, len_code});
        for (i = n_len_bytes - 1; i >= 0; i--)
            push_byte(len[8*i +: 8]);
        key = $urandom;
        if (masked)
            for (i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);

        // payload, unless the header already halted the parser
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : -1;
        if (!prs_halted)
            for (i = 0; i < int'(len); i++)
            begin
                if (i == cut)
                    break;
                push_byte(8'($urandom));
            end

        if (cut >= 0 || prs_halted || $urandom_range(0, 29) == 0)
        begin
            repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
            send_byte(8'($urandom), 1'b1, 1'b0, NO_RES);
        end
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        int p;
        int phase_len;
        int phase_end;
        parser_clear();
        prs_max_len = MAX_LEN_RESET;
        len_limits[0] = MAX_LEN_RESET;
        len_limits[1] = 63'd0;
        len_limits[2] = {63{1'b1}};
        len_limits[3] = 63'd9;
        len_limits[4] = 63'd130;
        len_limits[5] = 63'({$urandom, $urandom});
        len_limits[6] = 63'd301;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[r])
            send_byte(directed[r].rx, directed[r].rst_req, directed[r].pinned, directed[r].want);

        // sink holds off while a 64-byte text frame streams in back to back
        hold_pending = 1'b1;
        tx_burst = 1'b1;
        push_byte(8'h81);
        push_byte(8'd64);
        repeat (64) push_byte(8'($urandom));
        tx_burst = 1'b0;

        // random frames under each length limit; reset value first
        phase_len = (ITEM_TARGET - bytes_sent) / N_LIMITS;
        phase_end = bytes_sent;
        for (p = 0; p < N_LIMITS; p++)
        begin
            if (p > 0)
                write_max_len(len_limits[p]);
            phase_end += phase_len;
            while (bytes_sent < phase_end)
                send_frame();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result sink with random stalls and one long hold-off
    initial
    begin : result_sink
        int      gap;
        bit      rx_calm;
        result_t want;
        rx_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_pending)
            begin
                gap = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            else
                gap = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (pending_results.size() == 0)
                log_failure($sformatf("unexpected result: kind=%0d byte=%02h has_byte=%0b last=%0b",
                                      m_axis_tuser[2:0], m_axis_tdata, m_axis_tuser[3],
                                      m_axis_tlast));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[2:0] !== want.kind || m_axis_tdata !== want.data ||
                    m_axis_tuser[3] !== want.has_byte || m_axis_tlast !== want.last)
                    log_failure($sformatf({"result mismatch: expected kind=%0d byte=%02h ",
                                           "has_byte=%0b last=%0b, got kind=%0d byte=%02h ",
                                           "has_byte=%0b last=%0b"},
                                          want.kind, want.data, want.has_byte, want.last,
                                          m_axis_tuser[2:0], m_axis_tdata, m_axis_tuser[3],
                                          m_axis_tlast));
            end
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            @(negedge clk);
        end
    end

    // Watchdog: too many cycles without any transfer on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
